>>> hdl/pdc_pkg.sv
// Shared types and constants of the PID duty controller.
`default_nettype none

package pdc_pkg;

    // Default field widths
    localparam int ERROR_BITS_DEF      = 16;
    localparam int INTEGRATOR_BITS_DEF = 32;

    // Fixed widths of gains, register index and duty result
    localparam int GAIN_BITS    = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int DUTY_BITS    = 7;

    // Yaw wrap and duty limits
    localparam int YAW_HALF   = 180;
    localparam int YAW_FULL   = 360;
    localparam int YAW_LIMIT  = 70;
    localparam int MAIN_LIMIT = 80;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_KP      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KI      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KD      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIVISOR = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DERIV,
        ST_INTEG,
        ST_MAC,
        ST_RANGE,
        ST_DIVOUT,
        ST_FINISH
    } pdc_state_t;

    // Term of the control sum being accumulated
    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } pdc_term_t;

endpackage

`default_nettype wire

>>> hdl/pid_duty_controller.sv
// Bit-serial PID controller with anti-windup producing a duty cycle percent.
//
//  channel | handshake            | payload             | direction
//  --------+----------------------+---------------------+-------------
//  input   | in_valid, in_stall   | error, is_yaw       | into block
//  output  | out_valid, out_stall | duty_cycle, limited | out of block
//  config  | cfg_write            | cfg_index, cfg_data | into block
//
// Divider and sample period multiplier retire one bit per cycle side by side; the three gain
// products share one shift-add accumulator; the duty quotient takes seven steps unless the sum
// is negative or past the limit. Reset clears gains to 0, sample period and divisor to 1, and
// the stored error and integrator to 0. A word is accepted only while the sequencer is idle; a
// result waits in the output register, the next in the finish step, while the output stalls.
`default_nettype none

module pid_duty_controller #(
    parameter int ERROR_BITS      = pdc_pkg::ERROR_BITS_DEF,
    parameter int INTEGRATOR_BITS = pdc_pkg::INTEGRATOR_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [pdc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [pdc_pkg::GAIN_BITS-1:0]     cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [ERROR_BITS-1:0]      error,
    input  wire logic                              is_yaw,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [pdc_pkg::DUTY_BITS-1:0]          duty_cycle,
    output logic                                   limited
);

    import pdc_pkg::*;

    localparam int IB    = INTEGRATOR_BITS;
    localparam int GB    = GAIN_BITS;
    localparam int QB    = DUTY_BITS;
    localparam int EW    = ERROR_BITS + 1;
    localparam int DW    = EW + 1;
    localparam int YW    = ((EW > 10) ? EW : 10) + 1;
    localparam int PW    = EW + GB;
    localparam int AW    = ((IB > PW) ? IB : PW) + 1;
    localparam int SW    = ((IB > DW) ? IB : DW) + GB + 2;
    localparam int RW    = GB + QB;
    localparam int STEPS = (DW > GB) ? DW : GB;
    localparam int CW    = $clog2(STEPS);

    // Control and model state
    pdc_state_t                state_reg, state_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    pdc_term_t                 term_reg, term_next;
    logic [GB-1:0]             kp_reg, kp_next;
    logic [GB-1:0]             ki_reg, ki_next;
    logic [GB-1:0]             kd_reg, kd_next;
    logic [GB-1:0]             ts_reg, ts_next;
    logic [GB-1:0]             dv_reg, dv_next;
    logic signed [EW-1:0]      prev_reg, prev_next;
    logic signed [IB-1:0]      integ_reg, integ_next;
    logic                      out_valid_reg, out_valid_next;

    // Datapath
    logic                      yaw_reg, yaw_next;
    logic                      dneg_reg, dneg_next;
    logic [DW-1:0]             dvd_reg, dvd_next;
    logic [GB-1:0]             drem_reg, drem_next;
    logic [DW-1:0]             quo_reg, quo_next;
    logic signed [PW-1:0]      mcand_reg, mcand_next;
    logic [GB-1:0]             mplier_reg, mplier_next;
    logic signed [PW-1:0]      prod_reg, prod_next;
    logic signed [DW-1:0]      deriv_reg, deriv_next;
    logic signed [IB-1:0]      int_new_reg, int_new_next;
    logic signed [SW-1:0]      sum_reg, sum_next;
    logic signed [SW-1:0]      mac_x_reg, mac_x_next;
    logic [GB-1:0]             mac_g_reg, mac_g_next;
    logic [RW-1:0]             orem_reg, orem_next;
    logic [RW-1:0]             odvs_reg, odvs_next;
    logic [QB-1:0]             duty_reg, duty_next;
    logic                      lim_reg, lim_next;
    logic [QB-1:0]             duty_out_reg, duty_out_next;
    logic                      limited_out_reg, limited_out_next;

    logic                      load_out;

    // Sequencer and datapath next values
    always_comb
    begin
        logic signed [YW-1:0] e_ext;
        logic signed [YW-1:0] e_neg;
        logic signed [EW-1:0] e_w;
        logic signed [DW-1:0] diff;
        logic [GB:0]          rem_sh;
        logic                 qbit;
        logic signed [AW-1:0] int_sum;
        logic [GB-1:0]        dv_eff;
        logic [RW-1:0]        thr;
        logic signed [SW-1:0] neg_chk;
        logic [QB-1:0]        lim_val;

        state_next       = state_reg;
        cnt_next         = cnt_reg;
        term_next        = term_reg;
        kp_next          = kp_reg;
        ki_next          = ki_reg;
        kd_next          = kd_reg;
        ts_next          = ts_reg;
        dv_next          = dv_reg;
        prev_next        = prev_reg;
        integ_next       = integ_reg;
        yaw_next         = yaw_reg;
        dneg_next        = dneg_reg;
        dvd_next         = dvd_reg;
        drem_next        = drem_reg;
        quo_next         = quo_reg;
        mcand_next       = mcand_reg;
        mplier_next      = mplier_reg;
        prod_next        = prod_reg;
        deriv_next       = deriv_reg;
        int_new_next     = int_new_reg;
        sum_next         = sum_reg;
        mac_x_next       = mac_x_reg;
        mac_g_next       = mac_g_reg;
        orem_next        = orem_reg;
        odvs_next        = odvs_reg;
        duty_next        = duty_reg;
        lim_next         = lim_reg;
        duty_out_next    = duty_out_reg;
        limited_out_next = limited_out_reg;

        load_out = 1'b0;

        // Yaw: negate, then wrap once toward -180..180
        e_ext = YW'(error);
        e_neg = -e_ext;
        if (e_neg > $signed(YW'(YAW_HALF)))
        begin
            e_neg = e_neg - $signed(YW'(YAW_FULL));
        end
        else if (e_neg < -$signed(YW'(YAW_HALF)))
        begin
            e_neg = e_neg + $signed(YW'(YAW_FULL));
        end
        e_w  = is_yaw ? e_neg[EW-1:0] : e_ext[EW-1:0];
        diff = DW'(e_w) - DW'(prev_reg);

        // Derivative divider step
        rem_sh = {drem_reg, dvd_reg[DW-1]};
        qbit   = (rem_sh >= {1'b0, ts_reg});

        // Integrator update with saturation
        int_sum = AW'(integ_reg) + AW'(prod_reg);

        // Duty range check
        dv_eff  = (dv_reg == '0) ? GB'(1) : dv_reg;
        lim_val = yaw_reg ? QB'(YAW_LIMIT) : QB'(MAIN_LIMIT);
        thr     = yaw_reg ? RW'(dv_eff) * RW'(YAW_LIMIT + 1)
                          : RW'(dv_eff) * RW'(MAIN_LIMIT + 1);
        neg_chk = sum_reg + $signed({{(SW-GB){1'b0}}, dv_eff});

        // Register writes
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_KP:      kp_next = cfg_data;
                CFG_KI:      ki_next = cfg_data;
                CFG_KD:      kd_next = cfg_data;
                CFG_PERIOD:  ts_next = cfg_data;
                CFG_DIVISOR: dv_next = cfg_data;
                default:     ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    prev_next   = e_w;
                    yaw_next    = is_yaw;
                    dneg_next   = diff[DW-1];
                    dvd_next    = diff[DW-1] ? DW'(-diff) : DW'(diff);
                    drem_next   = '0;
                    quo_next    = '0;
                    mcand_next  = PW'(e_w);
                    mplier_next = ts_reg;
                    prod_next   = '0;
                    cnt_next    = '0;
                    state_next  = ST_DERIV;
                end
            end

            ST_DERIV:
            begin
                // Advance the divider and the multiplier one bit each
                if ({1'b0, cnt_reg} < (CW+1)'(DW))
                begin
                    drem_next = qbit ? GB'(rem_sh - {1'b0, ts_reg}) : rem_sh[GB-1:0];
                    quo_next  = {quo_reg[DW-2:0], qbit};
                    dvd_next  = {dvd_reg[DW-2:0], 1'b0};
                end
                if ({1'b0, cnt_reg} < (CW+1)'(GB))
                begin
                    if (mplier_reg[0])
                    begin
                        prod_next = prod_reg + mcand_reg;
                    end
                    mcand_next  = {mcand_reg[PW-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[GB-1:1]};
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(STEPS - 1))
                begin
                    state_next = ST_INTEG;
                end
            end

            ST_INTEG:
            begin
                if (ts_reg == '0)
                begin
                    deriv_next = '0;
                end
                else
                begin
                    deriv_next = dneg_reg ? -$signed(quo_reg) : $signed(quo_reg);
                end
                if (&int_sum[AW-1:IB-1] || ~|int_sum[AW-1:IB-1])
                begin
                    int_new_next = int_sum[IB-1:0];
                end
                else
                begin
                    int_new_next = int_sum[AW-1] ? {1'b1, {(IB-1){1'b0}}}
                                                 : {1'b0, {(IB-1){1'b1}}};
                end
                sum_next   = '0;
                mac_x_next = SW'(prev_reg);
                mac_g_next = kp_reg;
                term_next  = TERM_P;
                cnt_next   = '0;
                state_next = ST_MAC;
            end

            ST_MAC:
            begin
                // Add the shifted operand for each set gain bit
                if (mac_g_reg[0])
                begin
                    sum_next = sum_reg + mac_x_reg;
                end
                mac_x_next = {mac_x_reg[SW-2:0], 1'b0};
                mac_g_next = {1'b0, mac_g_reg[GB-1:1]};
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CW'(GB - 1))
                begin
                    cnt_next = '0;
                    case (term_reg)
                        TERM_P:
                        begin
                            mac_x_next = SW'(int_new_reg);
                            mac_g_next = ki_reg;
                            term_next  = TERM_I;
                        end
                        TERM_I:
                        begin
                            mac_x_next = SW'(deriv_reg);
                            mac_g_next = kd_reg;
                            term_next  = TERM_D;
                        end
                        default:
                        begin
                            state_next = ST_RANGE;
                        end
                    endcase
                end
            end

            ST_RANGE:
            begin
                if (sum_reg[SW-1])
                begin
                    // Negative sum: clamp only when the quotient is nonzero
                    duty_next  = '0;
                    lim_next   = neg_chk[SW-1] || (neg_chk == '0);
                    state_next = ST_FINISH;
                end
                else if (sum_reg >= $signed({{(SW-RW){1'b0}}, thr}))
                begin
                    duty_next  = lim_val;
                    lim_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    orem_next  = sum_reg[RW-1:0];
                    odvs_next  = RW'(dv_eff) << (QB - 1);
                    duty_next  = '0;
                    lim_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_DIVOUT;
                end
            end

            ST_DIVOUT:
            begin
                if (orem_reg >= odvs_reg)
                begin
                    orem_next = orem_reg - odvs_reg;
                end
                duty_next = {duty_reg[QB-2:0], (orem_reg >= odvs_reg)};
                odvs_next = {1'b0, odvs_reg[RW-1:1]};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(QB - 1))
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // Hand the word over and commit or drop the integration
                if (!out_valid_reg || !out_stall)
                begin
                    load_out         = 1'b1;
                    duty_out_next    = duty_reg;
                    limited_out_next = lim_reg;
                    if (!lim_reg)
                    begin
                        integ_next = int_new_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && out_stall) || load_out;
    end

    // Control and model state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            term_reg      <= TERM_P;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            ts_reg        <= GB'(1);
            dv_reg        <= GB'(1);
            prev_reg      <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            term_reg      <= term_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            kd_reg        <= kd_next;
            ts_reg        <= ts_next;
            dv_reg        <= dv_next;
            prev_reg      <= prev_next;
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        yaw_reg         <= yaw_next;
        dneg_reg        <= dneg_next;
        dvd_reg         <= dvd_next;
        drem_reg        <= drem_next;
        quo_reg         <= quo_next;
        mcand_reg       <= mcand_next;
        mplier_reg      <= mplier_next;
        prod_reg        <= prod_next;
        deriv_reg       <= deriv_next;
        int_new_reg     <= int_new_next;
        sum_reg         <= sum_next;
        mac_x_reg       <= mac_x_next;
        mac_g_reg       <= mac_g_next;
        orem_reg        <= orem_next;
        odvs_reg        <= odvs_next;
        duty_reg        <= duty_next;
        lim_reg         <= lim_next;
        duty_out_reg    <= duty_out_next;
        limited_out_reg <= limited_out_next;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign duty_cycle = duty_out_reg;
    assign limited    = limited_out_reg;

    // A new result word appears only out of the finish step
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result word appeared outside the finish step");

    // A clamped result leaves the integrator untouched
    a_antiwindup: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && lim_reg) |=> $stable(integ_reg))
        else $error("integrator changed on a clamped result");

    // Unclamped duty stays within the mode limit
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !lim_reg) |->
            (duty_reg <= (yaw_reg ? QB'(YAW_LIMIT) : QB'(MAIN_LIMIT))))
        else $error("unclamped duty above its limit");

    // An accepted word starts the divider and multiplier
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_DERIV && cnt_reg == '0))
        else $error("accepted word did not start the serial units");

endmodule

`default_nettype wire

>>> verif/pdc_duty_checker.sv
// Scoreboard for the PID duty controller: tracks registers, predicts and checks each duty word.
`timescale 1ns / 1ps

module pdc_duty_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [pdc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [pdc_pkg::GAIN_BITS-1:0]       cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [pdc_pkg::ERROR_BITS_DEF-1:0] error,
    input  logic                                is_yaw,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [pdc_pkg::DUTY_BITS-1:0]       duty_cycle,
    input  logic                                limited,
    output int                                  fail_count,
    output int                                  outstanding,
    output int                                  words_checked,
    output int                                  clamped_words
);

    import pdc_pkg::*;

    localparam longint INTEG_MAX = (longint'(1) <<< (INTEGRATOR_BITS_DEF - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty;
        logic                 limited;
    } duty_word_t;

    duty_word_t expected_duty_q[$];

    // Shadow registers and controller state
    logic [GAIN_BITS-1:0] gain_p = '0;
    logic [GAIN_BITS-1:0] gain_i = '0;
    logic [GAIN_BITS-1:0] gain_d = '0;
    logic [GAIN_BITS-1:0] step_len = 16'd1;
    logic [GAIN_BITS-1:0] scale_div = 16'd1;
    longint last_err = 0;
    longint integ_acc = 0;

    // Count a mismatch and log it on one line
    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        $display("MISMATCH %s on result word %0d: got %0d, expected %0d",
                 what, words_checked, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_words
        longint e_proc;
        longint deriv;
        longint saved;
        longint ctl_sum;
        longint duty;
        bit clamp;
        duty_word_t want;

        if (!rst_n)
        begin
            gain_p = '0;
            gain_i = '0;
            gain_d = '0;
            step_len = 16'd1;
            scale_div = 16'd1;
            last_err = 0;
            integ_acc = 0;
            expected_duty_q.delete();
            fail_count = 0;
            words_checked = 0;
            clamped_words = 0;
            outstanding <= 0;
        end
        else
        begin
            // Apply register writes
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_KP:      gain_p = cfg_data;
                    CFG_KI:      gain_i = cfg_data;
                    CFG_KD:      gain_d = cfg_data;
                    CFG_PERIOD:  step_len = cfg_data;
                    CFG_DIVISOR: scale_div = cfg_data;
                    default:     ;
                endcase
            end

            // Predict the duty word for an accepted error sample
            if (in_valid && !in_stall)
            begin
                e_proc = longint'(error);
                if (is_yaw)
                begin
                    // Negate, then wrap once toward -180..180
                    e_proc = -e_proc;
                    if (e_proc > YAW_HALF)
                        e_proc = e_proc - YAW_FULL;
                    else if (e_proc < -YAW_HALF)
                        e_proc = e_proc + YAW_FULL;
                end

                deriv = (step_len == 0) ? 64'sd0 : (e_proc - last_err) / longint'(step_len);
                saved = integ_acc;
                integ_acc = integ_acc + longint'(step_len) * e_proc;
                if (integ_acc > INTEG_MAX)
                    integ_acc = INTEG_MAX;
                else if (integ_acc < INTEG_MIN)
                    integ_acc = INTEG_MIN;

                ctl_sum = longint'(gain_p) * e_proc + longint'(gain_i) * integ_acc
                        + longint'(gain_d) * deriv;
                duty = ctl_sum / ((scale_div == 0) ? 64'sd1 : longint'(scale_div));
                last_err = e_proc;

                // Clamp to the mode's range; undo this step's integration when clamped
                clamp = 1'b1;
                if (is_yaw && duty > YAW_LIMIT)
                    duty = YAW_LIMIT;
                else if (duty > MAIN_LIMIT)
                    duty = MAIN_LIMIT;
                else if (duty < 0)
                    duty = 0;
                else
                    clamp = 1'b0;
                if (clamp)
                    integ_acc = saved;

                want.duty = duty[DUTY_BITS-1:0];
                want.limited = clamp;
                expected_duty_q.push_back(want);
            end

            // Compare each delivered word with the oldest prediction
            if (out_valid && !out_stall)
            begin
                words_checked++;
                if (expected_duty_q.size() == 0)
                    report_mismatch("unexpected duty word", longint'(duty_cycle), 0);
                else
                begin
                    want = expected_duty_q.pop_front();
                    if (duty_cycle !== want.duty)
                        report_mismatch("duty_cycle", longint'(duty_cycle), longint'(want.duty));
                    if (limited !== want.limited)
                        report_mismatch("limited", longint'(limited), longint'(want.limited));
                    if (want.limited)
                        clamped_words++;
                end
            end

            outstanding <= expected_duty_q.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// Top of the PID duty controller testbench: clock, reset, stimulus, stall pattern and verdict.
`timescale 1ns / 1ps

module tb_top;

    import pdc_pkg::*;

    localparam int NUM_PHASES     = 16;
    localparam int PHASE_WORDS    = 95;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    // Unmapped register index; writes to it must be ignored
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0]      cfg_index = CFG_KP;
    logic [GAIN_BITS-1:0]         cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [ERROR_BITS_DEF-1:0] error = '0;
    logic                         is_yaw = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [DUTY_BITS-1:0]         duty_cycle;
    logic                         limited;

    int fail_count;
    int outstanding;
    int words_checked;
    int clamped_words;

    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;
    int stuck_cycles = 0;
    int words_sent = 0;
    int yaw_words = 0;
    int settings_used = 0;
    int walk = 0;

    pid_duty_controller u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .error      (error),
        .is_yaw     (is_yaw),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .duty_cycle (duty_cycle),
        .limited    (limited)
    );

    pdc_duty_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .error         (error),
        .is_yaw        (is_yaw),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .duty_cycle    (duty_cycle),
        .limited       (limited),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .clamped_words (clamped_words)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // End the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("pid_duty_controller test failed");
            $finish;
        end
    end

    // Output stall pattern: random bursts, one long hold on request, none at the end
    initial
    begin : receiver
        int span;

        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                hold_req = 1'b0;
                span = HOLD_CYCLES;
            end
            else if (!gaps_on)
            begin
                out_stall <= 1'b0;
                span = 1;
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0, 1:
                    begin
                        out_stall <= 1'b1;
                        span = $urandom_range(1, 10);
                    end
                    7:
                    begin
                        out_stall <= 1'b0;
                        span = $urandom_range(20, 60);
                    end
                    default:
                    begin
                        out_stall <= 1'b0;
                        span = $urandom_range(1, 10);
                    end
                endcase
            end
            repeat (span) @(posedge clk);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [GAIN_BITS-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Write all five registers back to back, then drop the write enable
    task automatic load_gains(input logic [GAIN_BITS-1:0] p, input logic [GAIN_BITS-1:0] i,
                              input logic [GAIN_BITS-1:0] d, input logic [GAIN_BITS-1:0] ts,
                              input logic [GAIN_BITS-1:0] dv);
        write_reg(CFG_KP, p);
        write_reg(CFG_KI, i);
        write_reg(CFG_KD, d);
        write_reg(CFG_PERIOD, ts);
        write_reg(CFG_DIVISOR, dv);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Offer one error word and hold it until accepted; valid stays high afterwards
    task automatic send_word(input logic signed [ERROR_BITS_DEF-1:0] e, input logic yaw);
        in_valid <= 1'b1;
        error <= e;
        is_yaw <= yaw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (yaw)
            yaw_words++;
    endtask

    task automatic idle_gap(input bit allow);
        if (allow && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every predicted word has been delivered
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Error sample: mostly a bounded random walk when tracking, otherwise extremes and noise
    function automatic logic signed [ERROR_BITS_DEF-1:0] rand_error(input bit track);
        int pick;

        if (track && $urandom_range(0, 9) != 0)
        begin
            walk = walk + int'($urandom_range(0, 40)) - 20;
            if (walk > 2000)
                walk = 2000;
            else if (walk < -2000)
                walk = -2000;
            return walk[ERROR_BITS_DEF-1:0];
        end
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'sh8000;
                1:       return 16'sh7FFF;
                2:       return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        if (pick <= 4)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 800)) - 400);
    endfunction

    initial
    begin : stimulus
        int ph;
        int k;
        bit track;

        wait (rst_n === 1'b1);
        @(posedge clk);

        // Reset values: zero gains give duty 0 while the integrator still moves
        send_word(16'sd100, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(-16'sd200, 1'b1);
        send_word(16'sh7FFF, 1'b1);
        wait_drained();

        // Proportional only: duty follows the error up to the clamps
        load_gains(16'd1, 16'd0, 16'd0, 16'd1, 16'd1);
        send_word(16'sd45, 1'b0);
        send_word(16'sd80, 1'b0);
        send_word(16'sd81, 1'b0);
        send_word(-16'sd1, 1'b0);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b0);

        // Yaw: negation, single wrap at the half turn, limit 70 below the main limit
        send_word(16'sd180, 1'b1);
        send_word(-16'sd180, 1'b1);
        send_word(16'sd181, 1'b1);
        send_word(-16'sd181, 1'b1);
        send_word(-16'sd70, 1'b1);
        send_word(-16'sd71, 1'b1);
        send_word(-16'sd75, 1'b1);
        send_word(16'sh8000, 1'b1);
        send_word(16'sd0, 1'b1);
        wait_drained();

        // Zero sample period and zero divisor
        load_gains(16'd1, 16'd1, 16'd1, 16'd0, 16'd0);
        send_word(16'sd50, 1'b0);
        send_word(-16'sd20, 1'b0);
        send_word(16'sd30, 1'b0);
        wait_drained();

        // Drive the integrator into its upper saturation limit, then back down
        load_gains(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd1);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b0);
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            gaps_on = (ph < NUM_PHASES - 2);
            track = 1'b0;
            case (ph)
                0: load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: load_gains(16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                              16'($urandom_range(0, 2)), 16'd0, 16'd0);
                2:
                begin
                    write_reg(CFG_SPARE, 16'($urandom));
                    load_gains(16'd0, 16'd0, 16'd0, 16'($urandom), 16'd1);
                end
                default:
                begin
                    case (ph % 3)
                        0:
                        begin
                            // Pin the integrator to a known small value before tracking:
                            // saturate low, then step back up with zero gains
                            track = 1'b1;
                            walk = 0;
                            load_gains(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd1);
                            send_word(16'sh8000, 1'b0);
                            send_word(16'sh8000, 1'b0);
                            send_word(16'sh8000, 1'b0);
                            send_word(16'sh7FFF, 1'b0);
                            wait_drained();
                            load_gains(16'd0, 16'd0, 16'd0, 16'd3, 16'd1);
                            send_word(16'sh7FFF, 1'b0);
                            wait_drained();
                            load_gains(16'($urandom_range(1, 8)), 16'($urandom_range(0, 3)),
                                       16'($urandom_range(0, 16)), 16'($urandom_range(1, 4)),
                                       16'($urandom_range(1, 64)));
                        end
                        1: load_gains(16'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom), 16'($urandom));
                        default: load_gains(16'($urandom), 16'($urandom), 16'($urandom),
                                            16'($urandom_range(1, 16)),
                                            16'($urandom_range(16'h4000, 16'hFFFF)));
                    endcase
                end
            endcase

            // Back-pressure: hold the output while words keep coming
            if (ph == 3)
                hold_req = 1'b1;

            for (k = 0; k < PHASE_WORDS; k++)
            begin
                send_word(rand_error(track), $urandom_range(0, 2) == 0);
                if (ph == 5 && k == PHASE_WORDS / 2)
                    wait_drained();
                else
                    idle_gap(gaps_on && ph != 3);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d error words (%0d yaw) under %0d register settings;",
                 words_sent, yaw_words, settings_used);
        $display("checked %0d duty words, %0d of them clamped.", words_checked, clamped_words);
        if (fail_count == 0)
            $display("pid_duty_controller test passed");
        else
            $display("pid_duty_controller test failed");
        $finish;
    end

endmodule
